[rtl/core/ftm_pkg.sv]
// ----------------------------------------------------------------------------
// Fault table manager package
// Shared codes, table entry layout and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ftm_pkg;

	// Default table depth.
	localparam int MAX_FAULTS_DEF = 16;

	// Widths fixed by the port definition.
	localparam int ID_W    = 8;
	localparam int SEV_W   = 2;
	localparam int US_W    = 32;
	localparam int FUNC_W  = 2;
	localparam int SPEED_W = 16;
	localparam int THR_W   = 15;
	localparam int ACNT_W  = 5;
	localparam int CFG_W   = 32;
	localparam int CFGI_W  = 2;

	// Command codes.
	localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ACK    = 2'd2;

	// Severity codes; the fourth code is handled as a warning.
	localparam logic [SEV_W-1:0] SEV_WARNING   = 2'd0;
	localparam logic [SEV_W-1:0] SEV_LATCHED   = 2'd1;
	localparam logic [SEV_W-1:0] SEV_SELFCLEAR = 2'd2;

	// Configuration register indexes.
	localparam logic [CFGI_W-1:0] REG_SPEED_THR   = 2'd0;
	localparam logic [CFGI_W-1:0] REG_NR_TIMEOUT  = 2'd1;
	localparam logic [CFGI_W-1:0] REG_GATE_ID     = 2'd2;
	localparam logic [CFGI_W-1:0] REG_NR_ID       = 2'd3;

	// Configuration reset values.
	localparam logic [THR_W-1:0] SPEED_THR_RST  = 15'd26;
	localparam logic [US_W-1:0]  NR_TIMEOUT_RST = 32'd1000000;
	localparam logic [ID_W-1:0]  GATE_ID_RST    = 8'd254;
	localparam logic [ID_W-1:0]  NR_ID_RST      = 8'd255;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [SEV_W-1:0] sev;
		logic [US_W-1:0]  remaining;
	} entry_t;

	// What a table walk does with each entry it reads.
	typedef enum logic [1:0] {
		MODE_SCAN,
		MODE_TICK,
		MODE_ACK
	} mode_t;

	// Where the operands of a report come from.
	typedef enum logic [1:0] {
		SRC_ITEM,
		SRC_GATE,
		SRC_READY
	} src_t;

	typedef struct packed {
		logic  load;
		logic  walk;
		mode_t mode;
		src_t  src;
		logic  update;
		logic  commit;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              do_gate;
		logic              do_ready;
		logic              walk_done;
	} status_t;

endpackage

[rtl/core/fault_table_manager_core.sv]
// ----------------------------------------------------------------------------
// Fault table manager core
// Ordered table of active faults with reports, periodic ticks and acknowledge.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                Beat contents
// command   in         start high, busy low     func, fault_id, severity,
//                                               timeout_us, elapsed_us, speed,
//                                               gate_fault_n, gate_ready_n
// result    out        done strobe, one cycle   driver_enable, system_faulted,
//                                               active_count
// config    in         wr_en, no wait           wr_index, wr_data
//
// Every command beat yields exactly one result beat. A report and an
// acknowledge each walk the table once, over the N entries held; the table
// RAM is walked one entry per cycle through its single registered read port.
// A tick walks the table once more for each pin fault that newly appears.
// Reset empties the table at once (the entry count goes to zero) and holds
// the drivers disabled until the first tick. The receiver cannot stall: the
// result is shown for the single cycle in which done is high, and busy is
// already low in that cycle, so the next command can be taken then.
module fault_table_manager_core #(
	parameter int MAX_FAULTS = ftm_pkg::MAX_FAULTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Command beat.
	input  logic                               start,
	output logic                               busy,
	input  logic [ftm_pkg::FUNC_W-1:0]         func,
	input  logic [ftm_pkg::ID_W-1:0]           fault_id,
	input  logic [ftm_pkg::SEV_W-1:0]          severity,
	input  logic [ftm_pkg::US_W-1:0]           timeout_us,
	input  logic [ftm_pkg::US_W-1:0]           elapsed_us,
	input  logic signed [ftm_pkg::SPEED_W-1:0] speed,
	input  logic                               gate_fault_n,
	input  logic                               gate_ready_n,
	// Result beat.
	output logic                               done,
	output logic                               driver_enable,
	output logic                               system_faulted,
	output logic [ftm_pkg::ACNT_W-1:0]         active_count,
	// Configuration writes.
	input  logic                               wr_en,
	input  logic [ftm_pkg::CFGI_W-1:0]         wr_index,
	input  logic [ftm_pkg::CFG_W-1:0]          wr_data
);

	import ftm_pkg::*;

	// The controller only sequences; all table contents, counters and
	// configuration live in the datapath.
	cmd_t    cmd;
	status_t sts;

	ftm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.sts   (sts),
		.cmd   (cmd)
	);

	// The datapath owns the table RAM. A walk reads one entry per cycle; in a
	// tick or an acknowledge it writes the surviving entries back toward the
	// bottom of the table, which keeps their order and closes the gaps.
	ftm_dpath #(
		.MAX_FAULTS(MAX_FAULTS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.func          (func),
		.fault_id      (fault_id),
		.severity      (severity),
		.timeout_us    (timeout_us),
		.elapsed_us    (elapsed_us),
		.speed         (speed),
		.gate_fault_n  (gate_fault_n),
		.gate_ready_n  (gate_ready_n),
		.driver_enable (driver_enable),
		.system_faulted(system_faulted),
		.active_count  (active_count)
	);

endmodule

[rtl/core/ftm_ram.sv]
// ----------------------------------------------------------------------------
// Fault table RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ftm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/ftm_ctrl.sv]
// ----------------------------------------------------------------------------
// Fault table manager controller
// Sequences reports, pin checks and table walks for one command at a time.
// ----------------------------------------------------------------------------
module ftm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	input  ftm_pkg::status_t sts,
	output ftm_pkg::cmd_t    cmd
);

	import ftm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_GATE,
		ST_READY,
		ST_SCAN,
		ST_UPDATE,
		ST_PASS
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	src_t   src_q;

	// The done strobe is raised only on the way back to idle and cleared in
	// the idle state, so it is low in every busy state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			src_q   <= SRC_ITEM;
		end else begin
			case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (start && !busy_q) begin
						busy_q  <= 1'b1;
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					case (sts.func)
						FUNC_REPORT: begin
							src_q   <= SRC_ITEM;
							state_q <= ST_SCAN;
						end
						FUNC_TICK: state_q <= ST_GATE;
						FUNC_ACK:  state_q <= ST_PASS;
						default: begin
							busy_q  <= 1'b0;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_GATE: begin
					if (sts.do_gate) begin
						src_q   <= SRC_GATE;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_READY;
					end
				end
				ST_READY: begin
					if (sts.do_ready) begin
						src_q   <= SRC_READY;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_PASS;
					end
				end
				ST_SCAN: begin
					if (sts.walk_done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					case (src_q)
						SRC_ITEM: begin
							busy_q  <= 1'b0;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
						SRC_GATE: state_q <= ST_READY;
						default:  state_q <= ST_PASS;
					endcase
				end
				ST_PASS: begin
					if (sts.walk_done) begin
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && start && !busy_q;
		cmd.walk   = (state_q == ST_SCAN) || (state_q == ST_PASS);
		cmd.src    = src_q;
		cmd.update = (state_q == ST_UPDATE);
		cmd.commit = (state_q == ST_PASS) && sts.walk_done;
		if (state_q == ST_SCAN) begin
			cmd.mode = MODE_SCAN;
		end else if (sts.func == FUNC_TICK) begin
			cmd.mode = MODE_TICK;
		end else begin
			cmd.mode = MODE_ACK;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

[rtl/core/ftm_dpath.sv]
// ----------------------------------------------------------------------------
// Fault table manager datapath
// Configuration, status registers, table RAM and the walk/compaction logic.
// ----------------------------------------------------------------------------
module ftm_dpath #(
	parameter int MAX_FAULTS = ftm_pkg::MAX_FAULTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ftm_pkg::cmd_t                 cmd,
	output ftm_pkg::status_t              sts,
	input  logic                          wr_en,
	input  logic [ftm_pkg::CFGI_W-1:0]    wr_index,
	input  logic [ftm_pkg::CFG_W-1:0]     wr_data,
	input  logic [ftm_pkg::FUNC_W-1:0]    func,
	input  logic [ftm_pkg::ID_W-1:0]      fault_id,
	input  logic [ftm_pkg::SEV_W-1:0]     severity,
	input  logic [ftm_pkg::US_W-1:0]      timeout_us,
	input  logic [ftm_pkg::US_W-1:0]      elapsed_us,
	input  logic signed [ftm_pkg::SPEED_W-1:0] speed,
	input  logic                          gate_fault_n,
	input  logic                          gate_ready_n,
	output logic                          driver_enable,
	output logic                          system_faulted,
	output logic [ftm_pkg::ACNT_W-1:0]    active_count
);

	import ftm_pkg::*;

	localparam int IW = (MAX_FAULTS > 1) ? $clog2(MAX_FAULTS) : 1;
	localparam int CW = $clog2(MAX_FAULTS + 1);
	localparam int EW = $bits(entry_t);

	// Configuration registers.
	logic [THR_W-1:0] speed_thr_q;
	logic [US_W-1:0]  nr_timeout_q;
	logic [ID_W-1:0]  gate_id_q;
	logic [ID_W-1:0]  nr_id_q;

	// Architectural state.
	logic [CW-1:0] count_q;
	logic          flag_q;
	logic          gate_seen_q;
	logic          nr_seen_q;
	logic          enable_q;

	// Command operands captured at accept.
	logic [FUNC_W-1:0] func_q;
	logic [ID_W-1:0]   item_id_q;
	logic [SEV_W-1:0]  item_sev_q;
	logic [US_W-1:0]   item_tmo_q;
	logic [US_W-1:0]   elapsed_q;
	logic              stopped_q;
	logic              do_gate_q;
	logic              do_ready_q;

	// Walk state.
	logic [CW-1:0] rd_ptr_q;
	logic [CW-1:0] wr_ptr_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          found_q;
	logic [IW-1:0] match_idx_q;
	logic [SEV_W-1:0] match_sev_q;
	logic          acc_q;

	logic [SPEED_W:0]  speed_ext;
	logic [SPEED_W:0]  speed_mag;
	logic              stopped;
	logic [ID_W-1:0]   rep_id;
	logic [SEV_W-1:0]  rep_sev;
	logic [US_W-1:0]   rep_tmo;
	logic              rd_issue;
	logic [EW-1:0]     rdata;
	entry_t            rd_entry;
	entry_t            tick_entry;
	logic              keep;
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	entry_t            ram_wdata;

	// Speed magnitude; the most negative value maps to its true magnitude.
	assign speed_ext = {speed[SPEED_W-1], speed};
	assign speed_mag = speed[SPEED_W-1] ? ((SPEED_W+1)'(0) - speed_ext) : speed_ext;
	assign stopped   = speed_mag < {2'b00, speed_thr_q};

	always_comb begin
		case (cmd.src)
			SRC_GATE: begin
				rep_id  = gate_id_q;
				rep_sev = SEV_LATCHED;
				rep_tmo = '0;
			end
			SRC_READY: begin
				rep_id  = nr_id_q;
				rep_sev = SEV_SELFCLEAR;
				rep_tmo = nr_timeout_q;
			end
			default: begin
				rep_id  = item_id_q;
				rep_sev = item_sev_q;
				rep_tmo = item_tmo_q;
			end
		endcase
	end

	assign rd_issue = cmd.walk && (rd_ptr_q < count_q);
	assign rd_entry = entry_t'(rdata);

	always_comb begin
		tick_entry = rd_entry;
		keep       = 1'b1;
		case (cmd.mode)
			MODE_TICK: begin
				if (rd_entry.sev == SEV_SELFCLEAR) begin
					tick_entry.remaining = (rd_entry.remaining > elapsed_q) ?
						(rd_entry.remaining - elapsed_q) : '0;
					keep = !((tick_entry.remaining == '0) && stopped_q);
				end
			end
			MODE_ACK: keep = (rd_entry.sev != SEV_LATCHED);
			default:  keep = 1'b0;
		endcase
	end

	// Single write port: report update or compaction write-back.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_ptr_q[IW-1:0];
		ram_wdata = tick_entry;
		if (cmd.update) begin
			ram_wdata.id  = rep_id;
			ram_wdata.sev = rep_sev;
			ram_wdata.remaining = rep_tmo;
			if (found_q) begin
				ram_we        = (rep_sev == SEV_SELFCLEAR);
				ram_waddr     = match_idx_q;
				ram_wdata.sev = match_sev_q;
			end else begin
				ram_we    = (count_q < CW'(MAX_FAULTS));
				ram_waddr = count_q[IW-1:0];
			end
		end else if (cmd.walk && vld_s1 && (cmd.mode != MODE_SCAN)) begin
			ram_we = keep;
		end
	end

	ftm_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_FAULTS),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(EW'(ram_wdata)),
		.re   (rd_issue),
		.raddr(rd_ptr_q[IW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_thr_q  <= SPEED_THR_RST;
			nr_timeout_q <= NR_TIMEOUT_RST;
			gate_id_q    <= GATE_ID_RST;
			nr_id_q      <= NR_ID_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_SPEED_THR:  speed_thr_q  <= wr_data[THR_W-1:0];
				REG_NR_TIMEOUT: nr_timeout_q <= wr_data[US_W-1:0];
				REG_GATE_ID:    gate_id_q    <= wr_data[ID_W-1:0];
				REG_NR_ID:      nr_id_q      <= wr_data[ID_W-1:0];
				default: ;
			endcase
		end
	end

	// Operand capture; the pin edge decisions use the seen flags before update.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q     <= func;
			item_id_q  <= fault_id;
			item_sev_q <= (severity == SEV_SELFCLEAR || severity == SEV_LATCHED) ?
				severity : SEV_WARNING;
			item_tmo_q <= timeout_us;
			elapsed_q  <= elapsed_us;
			stopped_q  <= stopped;
			do_gate_q  <= (func == FUNC_TICK) && !gate_fault_n && !gate_seen_q;
			do_ready_q <= (func == FUNC_TICK) && !gate_ready_n && !nr_seen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			flag_q      <= 1'b0;
			gate_seen_q <= 1'b0;
			nr_seen_q   <= 1'b0;
			enable_q    <= 1'b0;
		end else begin
			if (cmd.load && (func == FUNC_TICK)) begin
				gate_seen_q <= !gate_fault_n;
				nr_seen_q   <= !gate_ready_n;
			end
			if (cmd.update && !found_q && (count_q < CW'(MAX_FAULTS))) begin
				count_q <= count_q + CW'(1);
				if (rep_sev != SEV_WARNING) begin
					flag_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				count_q <= wr_ptr_q;
				flag_q  <= acc_q;
				if (cmd.mode == MODE_TICK) begin
					enable_q <= !acc_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
			acc_q    <= 1'b0;
		end else if (!cmd.walk) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
			acc_q    <= 1'b0;
		end else begin
			vld_s1 <= rd_issue;
			if (rd_issue) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
			if (vld_s1) begin
				if (cmd.mode == MODE_SCAN) begin
					if (!found_q && (rd_entry.id == rep_id)) begin
						found_q <= 1'b1;
					end
				end else if (keep) begin
					wr_ptr_q <= wr_ptr_q + CW'(1);
					if (rd_entry.sev != SEV_WARNING) begin
						acc_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			idx_s1 <= rd_ptr_q[IW-1:0];
		end
		if (cmd.walk && vld_s1 && (cmd.mode == MODE_SCAN) && !found_q &&
			(rd_entry.id == rep_id)) begin
			match_idx_q <= idx_s1;
			match_sev_q <= rd_entry.sev;
		end
	end

	always_comb begin
		sts           = '0;
		sts.func      = func_q;
		sts.do_gate   = do_gate_q;
		sts.do_ready  = do_ready_q;
		sts.walk_done = (rd_ptr_q == count_q) && !vld_s1;
	end

	assign driver_enable  = enable_q;
	assign system_faulted = flag_q;
	assign active_count   = ACNT_W'(count_q);

endmodule
